@@ rtl/firrc_pkg.sv @@
// ============================================================================
// firrc_pkg
// Shared widths, reset values, register codes and control types of the
// run-time coefficient FIR filter.
// ============================================================================
package firrc_pkg;

    // Default number of taps in each delay line.
    localparam int MAX_TAPS_DEF = 8;

    // Field and word widths.
    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int ACC_W       = 32;
    localparam int WORD_W      = 64;
    localparam int TAP_CNT_W   = 4;
    localparam int CFG_INDEX_W = 4;
    localparam int COEF_ALL_W  = 2 * WORD_W;

    // The adder tree always has eight leaves (three registered levels);
    // leaves above the tap count of the instance are tied to zero.
    localparam int TREE_LEVELS = 3;
    localparam int TREE_LEAVES = 1 << TREE_LEVELS;

    // Product register plus tree levels, for each of the two stages.
    localparam int PIPE_DEPTH = 2 * (TREE_LEVELS + 1);

    // Register reset values.
    localparam logic [WORD_W-1:0]    COEF_LOW_RESET  = 64'h0001_0003_0003_0001;
    localparam logic [WORD_W-1:0]    COEF_HIGH_RESET = 64'h0;
    localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RESET = 4'd4;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_COEF_LOW  = 4'd0,
        REG_COEF_HIGH = 4'd1,
        REG_TAP_COUNT = 4'd2,
        REG_CASCADE   = 4'd3
    } cfg_reg_t;

    // Coefficients and tap count as seen by one filter stage.
    typedef struct packed {
        logic [COEF_ALL_W-1:0] coef_all;
        logic [TAP_CNT_W-1:0]  tap_count;
    } firrc_cfg_t;

    // Pipeline control of one filter stage.
    typedef struct packed {
        logic                   shift;
        logic [TREE_LEVELS-1:0] load;
    } firrc_ctrl_t;

endpackage

@@ rtl/firrc_cell.sv @@
// ============================================================================
// firrc_cell
// One tap of a delay line: a sample register that takes its neighbor's
// sample, and a registered product of the stored sample and its coefficient.
// ============================================================================
module firrc_cell (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                shift,
    input  logic                                tap_on,
    input  logic signed [firrc_pkg::COEF_W-1:0]   coef_i,
    input  logic signed [firrc_pkg::SAMPLE_W-1:0] sample_i,
    output logic signed [firrc_pkg::SAMPLE_W-1:0] sample_o,
    output logic        [firrc_pkg::ACC_W-1:0]    product_o
);

    logic signed [firrc_pkg::SAMPLE_W-1:0] sample_reg;
    logic signed [firrc_pkg::ACC_W-1:0]    product_reg;
    logic signed [firrc_pkg::ACC_W-1:0]    product_next;

    // The product uses the sample stored before this transfer shifts in.
    always_comb begin
        if (tap_on) begin
            product_next = coef_i * sample_reg;
        end else begin
            product_next = '0;
        end
    end

    // Delay tap: cleared by reset, moves only when an item enters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= '0;
        end else if (shift) begin
            sample_reg <= sample_i;
        end
    end

    // Product register: payload, no reset.
    always_ff @(posedge aclk) begin
        if (shift) begin
            product_reg <= product_next;
        end
    end

    assign sample_o  = sample_reg;
    assign product_o = product_reg;

endmodule

@@ rtl/firrc_stage.sv @@
// ============================================================================
// firrc_stage
// One direct-form filter stage: a row of tap cells followed by a registered
// three-level adder tree that wraps modulo 2^32.
// ============================================================================
module firrc_stage #(
    parameter int MAX_TAPS = firrc_pkg::MAX_TAPS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  firrc_pkg::firrc_ctrl_t                ctrl,
    input  firrc_pkg::firrc_cfg_t                 cfg,
    input  logic signed [firrc_pkg::SAMPLE_W-1:0] sample_in,
    output logic        [firrc_pkg::ACC_W-1:0]    sum_out
);

    logic signed [firrc_pkg::SAMPLE_W-1:0] tap_sample [MAX_TAPS];
    logic        [firrc_pkg::ACC_W-1:0]    leaf       [firrc_pkg::TREE_LEAVES];

    logic [firrc_pkg::ACC_W-1:0] sum4_reg [4];
    logic [firrc_pkg::ACC_W-1:0] sum2_reg [2];
    logic [firrc_pkg::ACC_W-1:0] sum_reg;

    // Row of cells; each cell takes the sample of its left neighbor.
    for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
        logic signed [firrc_pkg::SAMPLE_W-1:0] cell_in;
        logic                                  cell_on;

        if (k == 0) begin : g_first
            assign cell_in = sample_in;
        end else begin : g_rest
            assign cell_in = tap_sample[k-1];
        end

        assign cell_on = (firrc_pkg::TAP_CNT_W'(k) < cfg.tap_count);

        firrc_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift     (ctrl.shift),
            .tap_on    (cell_on),
            .coef_i    (cfg.coef_all[k*firrc_pkg::COEF_W +: firrc_pkg::COEF_W]),
            .sample_i  (cell_in),
            .sample_o  (tap_sample[k]),
            .product_o (leaf[k])
        );
    end

    // Tree leaves beyond the row of cells add nothing.
    for (genvar k = MAX_TAPS; k < firrc_pkg::TREE_LEAVES; k++) begin : g_pad
        assign leaf[k] = '0;
    end

    // Registered adder tree; each level loads on its own load bit.
    always_ff @(posedge aclk) begin
        if (ctrl.load[0]) begin
            for (int i = 0; i < 4; i++) begin
                sum4_reg[i] <= leaf[2*i] + leaf[2*i+1];
            end
        end
        if (ctrl.load[1]) begin
            for (int i = 0; i < 2; i++) begin
                sum2_reg[i] <= sum4_reg[2*i] + sum4_reg[2*i+1];
            end
        end
        if (ctrl.load[2]) begin
            sum_reg <= sum2_reg[0] + sum2_reg[1];
        end
    end

    assign sum_out = sum_reg;

endmodule

@@ rtl/fir_filter_runtime_coeff.sv @@
// ============================================================================
// fir_filter_runtime_coeff
// Direct-form FIR filter with run-time coefficients and an optional second
// stage fed with the low 16 bits of the first stage's sum.
// ============================================================================
//
//  Channel   Ports                               Direction  Contents
//  --------  ----------------------------------  ---------  -----------------
//  s_        s_tvalid, s_tready, s_tdata[15:0]   in         sample_in
//  m_        m_tvalid, m_tready, m_tdata[31:0]   out        filtered_out
//  cfg_      cfg_valid, cfg_ready, cfg_index,    in         register writes
//            cfg_data[63:0]
//
//  One sample is taken per clock cycle unless a full pipeline stalls. Each
//  result passes a product register and three adder tree levels per stage,
//  in two stages, whether or not the cascade is enabled.
//  Reset clears both delay lines and the pipeline; no clearing pass follows.
//  Each pipeline register holds its item until the next one frees up, so
//  samples keep coming in while a result waits, until the pipeline is full.
//
module fir_filter_runtime_coeff #(
    parameter int MAX_TAPS = firrc_pkg::MAX_TAPS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Input samples. tdata: [15:0] sample_in.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [firrc_pkg::SAMPLE_W-1:0]       s_tdata,
    // Results. tdata: [31:0] filtered_out.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [firrc_pkg::ACC_W-1:0]          m_tdata,
    // Register writes.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [firrc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [firrc_pkg::WORD_W-1:0]         cfg_data
);

    localparam int DEPTH = firrc_pkg::PIPE_DEPTH;
    localparam int HALF  = firrc_pkg::TREE_LEVELS + 1;

    // Configuration registers.
    logic [firrc_pkg::WORD_W-1:0]    coef_low_reg;
    logic [firrc_pkg::WORD_W-1:0]    coef_high_reg;
    logic [firrc_pkg::TAP_CNT_W-1:0] tap_count_reg;
    logic                            cascade_reg;

    // Pipeline control.
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic [DEPTH-1:0] load;

    // First-stage result carried alongside the second stage.
    logic [firrc_pkg::ACC_W-1:0] carry_reg [HALF];

    logic [firrc_pkg::ACC_W-1:0] stage1_sum;
    logic [firrc_pkg::ACC_W-1:0] stage2_sum;

    firrc_pkg::firrc_cfg_t  stage_cfg;
    firrc_pkg::firrc_ctrl_t ctrl1;
    firrc_pkg::firrc_ctrl_t ctrl2;

    // Register writes are always taken; unknown indexes are ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_low_reg  <= firrc_pkg::COEF_LOW_RESET;
            coef_high_reg <= firrc_pkg::COEF_HIGH_RESET;
            tap_count_reg <= firrc_pkg::TAP_COUNT_RESET;
            cascade_reg   <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (firrc_pkg::cfg_reg_t'(cfg_index))
                firrc_pkg::REG_COEF_LOW:  coef_low_reg  <= cfg_data;
                firrc_pkg::REG_COEF_HIGH: coef_high_reg <= cfg_data;
                firrc_pkg::REG_TAP_COUNT: tap_count_reg <= cfg_data[firrc_pkg::TAP_CNT_W-1:0];
                firrc_pkg::REG_CASCADE:   cascade_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign stage_cfg.coef_all  = {coef_high_reg, coef_low_reg};
    assign stage_cfg.tap_count = tap_count_reg;

    // A pipeline register may load when it is empty or its item moves on.
    always_comb begin
        load[DEPTH-1] = !valid_reg[DEPTH-1] || m_tready;
        for (int j = DEPTH - 2; j >= 0; j--) begin
            load[j] = !valid_reg[j] || load[j+1];
        end
    end

    always_comb begin
        valid_next[0] = load[0] ? s_tvalid : valid_reg[0];
        for (int j = 1; j < DEPTH; j++) begin
            valid_next[j] = load[j] ? valid_reg[j-1] : valid_reg[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = load[0];

    // Stage control: the first stage shifts on each sample transfer, the
    // second on each first-stage result while the cascade is on.
    assign ctrl1.shift = load[0] && s_tvalid;
    assign ctrl1.load  = load[HALF-1:1];
    assign ctrl2.shift = load[HALF] && valid_reg[HALF-1] && cascade_reg;
    assign ctrl2.load  = load[DEPTH-1:HALF+1];

    firrc_stage #(
        .MAX_TAPS (MAX_TAPS)
    ) u_stage1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl1),
        .cfg       (stage_cfg),
        .sample_in (s_tdata),
        .sum_out   (stage1_sum)
    );

    firrc_stage #(
        .MAX_TAPS (MAX_TAPS)
    ) u_stage2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl2),
        .cfg       (stage_cfg),
        .sample_in (stage1_sum[firrc_pkg::SAMPLE_W-1:0]),
        .sum_out   (stage2_sum)
    );

    // First-stage result travels in step with the second stage.
    always_ff @(posedge aclk) begin
        if (load[HALF]) begin
            carry_reg[0] <= stage1_sum;
        end
        for (int j = 1; j < HALF; j++) begin
            if (load[HALF+j]) begin
                carry_reg[j] <= carry_reg[j-1];
            end
        end
    end

    // Result selection; the user, not the block, keeps mode changes to an empty pipeline.
    assign m_tvalid = valid_reg[DEPTH-1];
    assign m_tdata  = cascade_reg ? stage2_sum : carry_reg[HALF-1];

    // A full pipeline with a stalled output takes no sample.
    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (&valid_reg) && !m_tready |-> !s_tready)
        else $error("sample taken while the pipeline is full and stalled");

    // Input is refused only when the first register holds an item.
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> valid_reg[0])
        else $error("input refused with an empty product register");

    // A sample transfer always fills the first register.
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> valid_reg[0])
        else $error("accepted sample lost at pipeline entry");

    // An item leaving the output is not repeated unless one stood behind it.
    a_no_repeat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !valid_reg[DEPTH-2] |=> !m_tvalid)
        else $error("result repeated after transfer");

endmodule

@@ test/fir_filter_runtime_coeff_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// fir_filter_runtime_coeff_tb
// Self-checking testbench of the run-time coefficient FIR filter. A predictor
// keeps its own copy of the coefficients, the tap count, the cascade mode and
// both delay lines, and works out each filtered output when its sample is
// transferred. Outputs are checked in order against those predictions. A few
// directed samples exercise the extremes. Random phases then vary the
// configuration, the idle pattern of both sides and back pressure.
// ============================================================================
module fir_filter_runtime_coeff_tb;

    import firrc_pkg::*;

    localparam int N_TAPS        = 8;
    localparam int PHASES        = 12;
    localparam int ITEMS_PER_PH  = 112;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_REPORTS   = 10;

    // Register indexes that the block has no register for.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LOW = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_TOP = 4'd15;

    // Stage selectors of the delay line store.
    localparam int STAGE_ONE = 0;
    localparam int STAGE_TWO = 1;

    // ------------------------------------------------------------------------
    // Predictor of the filter with its queue of pending outputs.
    // ------------------------------------------------------------------------
    class fir_response_tracker;
        logic [WORD_W-1:0]    coef_low;
        logic [WORD_W-1:0]    coef_high;
        logic [TAP_CNT_W-1:0] tap_count;
        logic                 cascade_on;
        logic [SAMPLE_W-1:0]  delay_taps [2][N_TAPS];
        logic [ACC_W-1:0]     expected_outputs [$];
        int                   mismatches;

        function new();
            coef_low   = COEF_LOW_RESET;
            coef_high  = COEF_HIGH_RESET;
            tap_count  = TAP_COUNT_RESET;
            cascade_on = 1'b0;
            mismatches = 0;
            foreach (delay_taps[s, k]) delay_taps[s][k] = '0;
        endfunction

        // Register write as the block sees it; unknown indexes change nothing.
        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [WORD_W-1:0] data);
            case (idx)
                REG_COEF_LOW:  coef_low   = data;
                REG_COEF_HIGH: coef_high  = data;
                REG_TAP_COUNT: tap_count  = data[TAP_CNT_W-1:0];
                REG_CASCADE:   cascade_on = data[0];
                default: ;
            endcase
        endfunction

        // Sum over the stored samples of one stage, then shift in the new one.
        function logic [ACC_W-1:0] stage_sum(int stage, logic [SAMPLE_W-1:0] x);
            logic [ACC_W-1:0]      acc;
            logic [COEF_ALL_W-1:0] coef_all;
            logic signed [COEF_W-1:0]   c;
            logic signed [SAMPLE_W-1:0] d;
            int k;
            acc      = '0;
            coef_all = {coef_high, coef_low};
            for (k = 0; k < N_TAPS; k++) begin
                if (k < int'(tap_count)) begin
                    c   = coef_all[COEF_W*k +: COEF_W];
                    d   = delay_taps[stage][k];
                    acc = acc + ACC_W'(int'(c) * int'(d));
                end
            end
            for (k = N_TAPS - 1; k > 0; k--) delay_taps[stage][k] = delay_taps[stage][k-1];
            delay_taps[stage][0] = x;
            return acc;
        endfunction

        // A sample was transferred: predict its output.
        function void take_sample(logic [SAMPLE_W-1:0] x);
            logic [ACC_W-1:0] y;
            y = stage_sum(STAGE_ONE, x);
            if (cascade_on) y = stage_sum(STAGE_TWO, y[SAMPLE_W-1:0]);
            expected_outputs.push_back(y);
        endfunction

        // An output was transferred: compare it with the oldest prediction.
        function void check_output(logic [ACC_W-1:0] actual);
            logic [ACC_W-1:0] want;
            if (expected_outputs.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: output 0x%08h with no sample pending", $realtime, actual);
            end else begin
                want = expected_outputs.pop_front();
                if (actual !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: filtered_out expected %0d (0x%08h), got %0d (0x%08h)",
                                 $realtime, $signed(want), want, $signed(actual), actual);
                end
            end
        endfunction

        function int pending();
            return expected_outputs.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block.
    // ------------------------------------------------------------------------
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [SAMPLE_W-1:0]    s_tdata   = '0;     // [15:0] sample_in
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [ACC_W-1:0]       m_tdata;            // [31:0] filtered_out
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]      cfg_data  = '0;

    fir_response_tracker tracker = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int cycle_count    = 0;

    fir_filter_runtime_coeff u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: a long hold-off when asked, random stalls otherwise.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor of every transfer on the three channels.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) tracker.check_output(m_tdata);
            if (s_tvalid && s_tready) tracker.take_sample(s_tdata);
            if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks. Each one returns just after a rising edge.
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic [SAMPLE_W-1:0] x);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [WORD_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Stop offering samples and wait until every output has come out.
    task automatic drain_outputs();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_filter(input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi,
                              input logic [WORD_W-1:0] taps, input logic [WORD_W-1:0] casc);
        write_reg(REG_COEF_LOW, lo);
        write_reg(REG_COEF_HIGH, hi);
        write_reg(REG_TAP_COUNT, taps);
        write_reg(REG_CASCADE, casc);
    endtask

    // ------------------------------------------------------------------------
    // Random value helpers.
    // ------------------------------------------------------------------------
    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] random_coef_word();
        logic [WORD_W-1:0] w;
        int i;
        case ($urandom_range(7))
            0: w = {4{16'h8000}};
            1: w = {4{16'h7FFF}};
            2: for (i = 0; i < 4; i++) w[16*i +: 16] = 16'($signed($urandom_range(8)) - 4);
            default: w = {$urandom, $urandom};
        endcase
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] random_tap_word();
        logic [WORD_W-1:0] w;
        w = {$urandom, $urandom};
        if ($urandom_range(3) == 0) w[TAP_CNT_W-1:0] = TAP_CNT_W'($urandom_range(15));
        else                        w[TAP_CNT_W-1:0] = TAP_CNT_W'($urandom_range(1, 8));
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        logic [WORD_W-1:0] lo, hi, taps, casc;
        int ph, n;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset coefficients 1, 3, 3, 1: full-scale samples and an impulse.
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0001);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'h0000);
        drain_outputs();

        // Most negative coefficients and samples on all taps, tap count above
        // the maximum: the sum wraps.
        set_filter({4{16'h8000}}, {4{16'h8000}}, 64'd15, 64'd0);
        repeat (9) send_sample(16'h8000);
        drain_outputs();

        // Tap count zero with the cascade on: both stages sum to nothing.
        set_filter({4{16'h7FFF}}, {4{16'h7FFF}}, 64'd0, 64'd1);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        drain_outputs();

        // Writes to unknown indexes must leave the registers alone.
        set_filter(COEF_LOW_RESET, {4{16'h7FFF}}, 64'd8, 64'd1);
        write_reg(REG_UNUSED_LOW, '1);
        write_reg(REG_UNUSED_TOP, '1);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h1234);
        send_sample(16'hFFFF);
        send_sample(16'h4000);
        send_sample(16'hC000);
        drain_outputs();

        // Random phases, each with its own setting and idle pattern.
        for (ph = 0; ph < PHASES; ph++) begin
            lo   = random_coef_word();
            hi   = random_coef_word();
            taps = random_tap_word();
            casc = {$urandom, $urandom};
            case (ph)
                0: begin taps[TAP_CNT_W-1:0] = 4'd1; casc[0] = 1'b0; end
                1: begin
                    lo = {4{16'h8000}};
                    hi = {4{16'h7FFF}};
                    taps[TAP_CNT_W-1:0] = 4'd8;
                    casc[0] = 1'b1;
                end
                2: taps[TAP_CNT_W-1:0] = 4'd0;
                3: begin taps[TAP_CNT_W-1:0] = 4'd15; casc[0] = 1'b1; end
                default: ;
            endcase
            set_filter(lo, hi, taps, casc);
            if ($urandom_range(2) == 0) write_reg(CFG_INDEX_W'($urandom_range(4, 15)),
                                                  {$urandom, $urandom});

            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase

            for (n = 0; n < ITEMS_PER_PH; n++) begin
                // Back pressure: the receiver holds off while samples keep
                // coming, so the pipeline fills and the input stalls.
                if (ph == 4 && n == 10) hold_left = HOLD_CYCLES;
                // The sender waits until every output is out, then resumes.
                if (ph == 5 && n == 50) begin
                    @(negedge aclk);
                    s_tvalid <= 1'b0;
                    @(posedge aclk);
                    while (tracker.pending() != 0) @(posedge aclk);
                end
                send_sample(random_sample());
            end
            drain_outputs();
        end

        if (tracker.pending() != 0)
            $display("%0d predicted outputs never arrived", tracker.pending());
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
